// ===== sv/kwm_pkg.sv =====
// Package for the k-way sorted merge: sizes, word types, cell interface, FSM states.
package kwm_pkg;

    // Sizes
    localparam int MAX_LISTS = 16;
    localparam int MAX_LEN   = 16;
    localparam int LIST_W    = $clog2(MAX_LISTS);
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int DEPTH     = MAX_LISTS * MAX_LEN;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int REM_W     = $clog2(DEPTH + 1);
    localparam int CNT_W     = (LIST_W > 0) ? LIST_W : 1;
    localparam int VAL_W     = 32;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Input word
    typedef struct packed {
        logic                    cmd;
        logic [3:0]              list_index;
        logic signed [VAL_W-1:0] value;
    } req_t;

    // Result word
    typedef struct packed {
        logic signed [VAL_W-1:0] merged_value;
        logic                    empty_res;
        logic                    last;
    } rsp_t;

    // Running minimum handed from cell to cell
    typedef struct packed {
        logic                    found;
        logic [LIST_W-1:0]       idx;
        logic signed [VAL_W-1:0] val;
    } token_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic                    clear;
        logic                    load;
        logic                    advance;
        logic                    head_wr;
        logic signed [VAL_W-1:0] head_val;
    } cell_ctl_t;

    // Per-cell status back to the sequencer
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] rp;
    } cell_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT,
        ST_FILL
    } state_t;

endpackage

// ===== sv/kwm_ram.sv =====
// Generic simple dual-port RAM with registered read.
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/kwm_cell.sv =====
// One list cell: length, read pointer, cached head, and one stage of the minimum chain.
module kwm_cell
    import kwm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [LIST_W-1:0] cell_id,
    input  cell_ctl_t         ctl,
    input  token_t            tok_in,
    output token_t            tok_out,
    output cell_stat_t        stat
);

    logic [LEN_W-1:0]        len_reg, len_next;
    logic [LEN_W-1:0]        rp_reg, rp_next;
    logic signed [VAL_W-1:0] head_reg;
    token_t                  tok_reg, tok_next;
    logic [LEN_W-1:0]        eff_len, eff_rp;
    logic                    has_elem;

    // List bookkeeping; a set clear wipes length and pointer
    always_comb
    begin
        eff_len  = ctl.clear ? '0 : len_reg;
        eff_rp   = ctl.clear ? '0 : rp_reg;
        len_next = ctl.load ? eff_len + LEN_W'(1) : eff_len;
        rp_next  = ctl.advance ? eff_rp + LEN_W'(1) : eff_rp;
    end

    // Compare own head against the incoming minimum; ties keep the lower list
    always_comb
    begin
        has_elem = (rp_reg < len_reg);
        tok_next = tok_in;
        if (has_elem && (!tok_in.found || (head_reg < tok_in.val)))
        begin
            tok_next.found = 1'b1;
            tok_next.idx   = cell_id;
            tok_next.val   = head_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            rp_reg  <= '0;
            tok_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            rp_reg  <= rp_next;
            tok_reg <= tok_next;
        end
    end

    // Head cache
    always_ff @(posedge clk)
    begin
        if (ctl.head_wr)
        begin
            head_reg <= ctl.head_val;
        end
    end

    assign tok_out  = tok_reg;
    assign stat.len = len_reg;
    assign stat.rp  = rp_reg;

endmodule

// ===== sv/k_way_sorted_merge_top.sv =====
// Top level of the k-way sorted merge: sequencer, cell chain and element RAM.
//
//  channel | valid     | ready     | word | moves
//  --------+-----------+-----------+------+---------------------------------
//  request | req_valid | req_ready | req  | load (append) or pop command
//  result  | rsp_valid | rsp_ready | rsp  | one word per pop, none per load
//
// A load is handled in the idle state. A pop walks the running minimum along the
// cell chain one cell per cycle; the result state then commits the result and, for a
// non-empty pop, the fill state refills the winning cell's head from the element RAM.
// Reset clears all lengths, pointers and counts at once; RAM contents are not cleared.
// A pop waits in the result stage while an earlier result is unaccepted; loads wait too.
module k_way_sorted_merge_top
    import kwm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                merging_reg, merging_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [LIST_W-1:0]   fill_idx_reg, fill_idx_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;

    cell_ctl_t           ctl [MAX_LISTS];
    cell_stat_t          stat [MAX_LISTS];
    token_t              tok [MAX_LISTS+1];

    logic                ram_wr, ram_rd;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [VAL_W-1:0]    ram_rdata;

    logic                accept, clear_set, drop, load_ok, commit;
    logic [LIST_W-1:0]   sel_idx;
    logic [LEN_W-1:0]    sel_len;
    logic                any_left;

    // Cell chain; the head of the chain sees an empty minimum
    assign tok[0] = '0;

    for (genvar g = 0; g < MAX_LISTS; g++)
    begin : g_cell
        kwm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cell_id (LIST_W'(g)),
            .ctl     (ctl[g]),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1]),
            .stat    (stat[g])
        );
    end

    // Element store
    kwm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .wr_en (ram_wr),
        .waddr (ram_waddr),
        .wdata (req.value),
        .rd_en (ram_rd),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign sel_idx   = LIST_W'(req.list_index);

    // Load decode: drop mid-merge, start a new set after drain
    always_comb
    begin
        clear_set = merging_reg && (rem_reg == '0);
        drop      = merging_reg && (rem_reg != '0);
        sel_len   = clear_set ? '0 : stat[sel_idx].len;
        load_ok   = !drop && (32'(req.list_index) < MAX_LISTS)
                    && (32'(sel_len) < MAX_LEN);
        ram_waddr = ADDR_W'(32'(req.list_index) * MAX_LEN + 32'(sel_len));
    end

    // Sequencer: next state, cell controls, RAM and result register
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        merging_next   = merging_reg;
        rem_next       = rem_reg;
        fill_idx_next  = fill_idx_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        ram_wr         = 1'b0;
        ram_rd         = 1'b0;
        ram_raddr      = ADDR_W'(32'(tok[MAX_LISTS].idx) * MAX_LEN
                                 + 32'(stat[tok[MAX_LISTS].idx].rp) + 1);
        commit         = 1'b0;
        for (int i = 0; i < MAX_LISTS; i++)
        begin
            ctl[i] = '0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.cmd == CMD_LOAD))
                begin
                    if (clear_set)
                    begin
                        merging_next = 1'b0;
                        rem_next     = '0;
                        for (int i = 0; i < MAX_LISTS; i++)
                        begin
                            ctl[i].clear = 1'b1;
                        end
                    end
                    if (load_ok)
                    begin
                        ram_wr                = 1'b1;
                        rem_next              = (clear_set ? '0 : rem_reg) + REM_W'(1);
                        ctl[sel_idx].load     = 1'b1;
                        ctl[sel_idx].head_wr  = (sel_len == '0);
                        ctl[sel_idx].head_val = req.value;
                    end
                end
                else if (accept)
                begin
                    merging_next = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (32'(cnt_reg) == MAX_LISTS - 1)
                begin
                    state_next = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                commit = !rsp_valid_reg || rsp_ready;
                if (commit)
                begin
                    rsp_valid_next = 1'b1;
                    if (tok[MAX_LISTS].found)
                    begin
                        ctl[tok[MAX_LISTS].idx].advance = 1'b1;
                        ram_rd                = 1'b1;
                        fill_idx_next         = tok[MAX_LISTS].idx;
                        rem_next              = (rem_reg != '0) ? rem_reg - REM_W'(1) : rem_reg;
                        rsp_next.merged_value = tok[MAX_LISTS].val;
                        rsp_next.empty_res    = 1'b0;
                        rsp_next.last         = (rem_reg == REM_W'(1));
                        state_next            = ST_FILL;
                    end
                    else
                    begin
                        rsp_next.merged_value = '0;
                        rsp_next.empty_res    = 1'b1;
                        rsp_next.last         = 1'b0;
                        state_next            = ST_IDLE;
                    end
                end
            end

            ST_FILL:
            begin
                ctl[fill_idx_reg].head_wr  = 1'b1;
                ctl[fill_idx_reg].head_val = ram_rdata;
                state_next                 = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            merging_reg   <= 1'b0;
            rem_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            merging_reg   <= merging_next;
            rem_reg       <= rem_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        fill_idx_reg <= fill_idx_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Any unread element left in any cell
    always_comb
    begin
        any_left = 1'b0;
        for (int i = 0; i < MAX_LISTS; i++)
        begin
            any_left = any_left | (stat[i].rp < stat[i].len);
        end
    end

    // Remaining count agrees with the cells
    a_rem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == '0) |-> !any_left)
        else $error("remaining count zero while a cell holds unread elements");

    // Chain result agrees with the remaining count
    a_found_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT) |-> (tok[MAX_LISTS].found == (rem_reg != '0)))
        else $error("chain minimum disagrees with remaining count");

    // A committed non-empty pop is followed by a head refill
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && tok[MAX_LISTS].found) |=> (state_reg == ST_FILL))
        else $error("pop committed without head refill");

endmodule

// ===== tb/k_way_sorted_merge_top_test.sv =====
// Self-checking testbench for the k-way sorted merge: directed rows, then random sets.
`timescale 1ns / 1ps

module k_way_sorted_merge_top_test;
    import kwm_pkg::*;

    // Directed stimulus row; value steps by one on each repeat
    typedef struct {
        logic cmd;
        int   idx;
        int   value;
        int   reps;
        bit   pinned;
        rsp_t want;
    } dir_row_t;

    // Hand-written result that overrides the predictor for one word
    typedef struct packed {
        logic pinned;
        rsp_t want;
    } pin_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // Shadow copy of the merge state
    logic signed [VAL_W-1:0] elem_mem [MAX_LISTS][MAX_LEN];
    logic [LEN_W-1:0]        list_len [MAX_LISTS];
    logic [LEN_W-1:0]        read_ptr [MAX_LISTS];
    bit                      in_merge;
    int                      pending_elems;

    rsp_t     pop_results_due [$];
    pin_t     pinned_due [$];
    dir_row_t rows [$];

    int fail_count;
    int items_sent;
    int send_idle_pct;
    int recv_stall_pct;

    k_way_sorted_merge_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Drop all lists and pointers, as after reset or a drained set
    function automatic void clear_lists();
        int k;
        for (k = 0; k < MAX_LISTS; k++)
        begin
            list_len[k] = '0;
            read_ptr[k] = '0;
        end
        pending_elems = 0;
        in_merge      = 1'b0;
    endfunction

    // Apply one accepted word to the shadow state; returns 1 when a result is due
    function automatic bit merge_step(input req_t w, output rsp_t r);
        bit                      found;
        int                      win;
        int                      k;
        int                      li;
        logic signed [VAL_W-1:0] win_val;
        found   = 1'b0;
        win     = 0;
        win_val = '0;
        r       = '0;
        li      = int'(w.list_index);
        if (w.cmd == CMD_LOAD)
        begin
            if (in_merge)
            begin
                // mid-merge loads are dropped; after a drain they open a new set
                if (pending_elems != 0)
                    return 1'b0;
                clear_lists();
            end
            if (li >= MAX_LISTS || list_len[li] >= MAX_LEN)
                return 1'b0;
            elem_mem[li][list_len[li]] = w.value;
            list_len[li]               = list_len[li] + 1'b1;
            pending_elems++;
            return 1'b0;
        end
        in_merge = 1'b1;
        // smallest head, lowest list index wins ties
        for (k = 0; k < MAX_LISTS; k++)
        begin
            if (read_ptr[k] < list_len[k])
            begin
                if (!found || elem_mem[k][read_ptr[k]] < win_val)
                begin
                    found   = 1'b1;
                    win     = k;
                    win_val = elem_mem[k][read_ptr[k]];
                end
            end
        end
        if (!found)
        begin
            r.empty_res = 1'b1;
            return 1'b1;
        end
        read_ptr[win] = read_ptr[win] + 1'b1;
        if (pending_elems != 0)
            pending_elems--;
        r.merged_value = win_val;
        r.last         = (pending_elems == 0);
        return 1'b1;
    endfunction

    function automatic req_t mk_req(input logic cmd, input int idx, input int val);
        req_t w;
        w.cmd        = cmd;
        w.list_index = idx[3:0];
        w.value      = val;
        return w;
    endfunction

    function automatic void add_row(input logic cmd, input int idx, input int val, input int reps,
                                    input bit pinned, input int mv, input logic emp,
                                    input logic lst);
        dir_row_t d;
        d.cmd                = cmd;
        d.idx                = idx;
        d.value              = val;
        d.reps               = reps;
        d.pinned             = pinned;
        d.want.merged_value  = mv;
        d.want.empty_res     = emp;
        d.want.last          = lst;
        rows.insert(rows.size(), d);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        rsp_t predicted;
        rsp_t due;
        pin_t pin;
        bit   produced;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                pin      = pinned_due.pop_front();
                produced = merge_step(req, predicted);
                if (produced)
                    pop_results_due.insert(pop_results_due.size(),
                                           pin.pinned ? pin.want : predicted);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (pop_results_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word: value %h empty %b last %b",
                                 rsp.merged_value, rsp.empty_res, rsp.last);
                end
                else
                begin
                    due = pop_results_due.pop_front();
                    check_field("merged_value", due.merged_value, rsp.merged_value);
                    check_field("empty_res", 32'(due.empty_res), 32'(rsp.empty_res));
                    check_field("last", 32'(due.last), 32'(rsp.last));
                end
            end
        end
    end

    // Result-side backpressure
    always @(negedge clk)
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Present one word from a falling edge and hold it until accepted
    task automatic send_word(input req_t w, input bit pinned, input rsp_t want);
        int   gap;
        pin_t pin;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pin.pinned = pinned;
        pin.want   = want;
        pinned_due.insert(pinned_due.size(), pin);
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Hold the sender off until every pending result is in, then let the block settle
    task automatic settle_results();
        int spins;
        spins = 0;
        req_valid <= 1'b0;
        while (pop_results_due.size() != 0 && spins < 50000)
        begin
            @(negedge clk);
            spins++;
        end
        repeat (30) @(negedge clk);
    endtask

    // One random set: mostly load-then-drain, some noise and broken orderings
    task automatic run_random_set();
        int kind;
        int n_loads;
        int spread;
        int first;
        int style;
        int n_pops;
        int k;
        int idx;
        int v;
        int run_val [MAX_LISTS];
        kind = $urandom_range(9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 8))
                send_word(mk_req(($urandom_range(1) == 0) ? CMD_LOAD : CMD_POP,
                                 $urandom_range(15), $urandom), 1'b0, '0);
            return;
        end
        if ($urandom_range(24) == 0)
        begin
            // near-full store
            n_loads = $urandom_range(DEPTH, DEPTH + 24);
            spread  = MAX_LISTS;
        end
        else
        begin
            n_loads = $urandom_range(1, 24);
            spread  = $urandom_range(1, MAX_LISTS);
        end
        first = $urandom_range(MAX_LISTS - 1);
        style = $urandom_range(2);
        for (k = 0; k < MAX_LISTS; k++)
            run_val[k] = -int'($urandom_range(1 << 30));
        for (k = 0; k < n_loads; k++)
        begin
            idx = (first + $urandom_range(spread - 1)) % MAX_LISTS;
            case (style)
                0: v = $urandom;
                1:
                begin
                    run_val[idx] += $urandom_range(50);
                    v = run_val[idx];
                end
                default: v = int'($urandom_range(6)) - 3;
            endcase
            send_word(mk_req(CMD_LOAD, idx, v), 1'b0, '0);
            // broken ordering: pop before the set is complete
            if (kind == 1 && $urandom_range(15) == 0)
                send_word(mk_req(CMD_POP, $urandom_range(15), $urandom), 1'b0, '0);
        end
        n_pops = pending_elems + $urandom_range(2);
        for (k = 0; k < n_pops; k++)
        begin
            send_word(mk_req(CMD_POP, $urandom_range(15), $urandom), 1'b0, '0);
            if ($urandom_range(19) == 0)
                send_word(mk_req(CMD_LOAD, $urandom_range(15), $urandom), 1'b0, '0);
        end
    endtask

    // Stimulus
    initial
    begin
        int r;
        int k;
        int phase;
        int target;
        fail_count     = 0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        clear_lists();

        // pop on an empty block
        add_row(CMD_POP,  0, 0, 2, 1'b1, 0, 1'b1, 1'b0);
        // extremes, a tie between list 3 and list 6, an unsorted list
        add_row(CMD_LOAD, 0, 32'h7FFF_FFFF, 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_LOAD, 15, 32'h8000_0000, 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_LOAD, 3, 0, 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_LOAD, 3, -1, 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_LOAD, 6, 0, 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_POP,  0, 0, 1, 1'b1, 32'h8000_0000, 1'b0, 1'b0);
        add_row(CMD_POP,  0, 0, 1, 1'b0, 0, 1'b0, 1'b0);
        // load during merge is dropped
        add_row(CMD_LOAD, 5, 5, 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_POP,  0, 0, 2, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_POP,  0, 0, 1, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b1);
        add_row(CMD_POP,  0, 0, 2, 1'b1, 0, 1'b1, 1'b0);
        // load after drain opens a new set; list 9 overfills by one
        add_row(CMD_LOAD, 9, -100, MAX_LEN + 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_LOAD, 4, -100, 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_POP,  0, 0, MAX_LEN + 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_POP,  0, 0, 1, 1'b1, 0, 1'b1, 1'b0);
        add_row(CMD_LOAD, 1, 32'h5555_5555, 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_LOAD, 1, 32'hAAAA_AAAA, 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_LOAD, 2, 32'h0000_FFFF, 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_POP,  0, 0, 3, 1'b0, 0, 1'b0, 1'b0);
        // early pop drains a one-element set, so the next load restarts
        add_row(CMD_LOAD, 8, 1, 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_POP,  0, 0, 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_LOAD, 8, 2, 1, 1'b0, 0, 1'b0, 1'b0);
        add_row(CMD_POP,  0, 0, 1, 1'b1, 2, 1'b0, 1'b1);

        // Reset
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part
        for (r = 0; r < rows.size(); r++)
            for (k = 0; k < rows[r].reps; k++)
                send_word(mk_req(rows[r].cmd, rows[r].idx, rows[r].value + k),
                          rows[r].pinned, rows[r].want);
        settle_results();

        // Random part: no idling, sender idle, receiver stall, both
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default:
                begin
                    send_idle_pct  = 31;
                    recv_stall_pct = 31;
                end
            endcase
            target = items_sent + 1650 / 4;
            while (items_sent < target)
                run_random_set();
            settle_results();
        end

        fail_count += pop_results_due.size();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
